// ===== design/pcfd_pkg.sv =====
// Shared types and constants for the PDM CIC/FIR decimator.
// No dependencies.
package pcfd_pkg;
    localparam int NUM_STAGES_DEF = 4;
    localparam int COMB_DELAY_DEF = 1;
    localparam int FIR_TAPS_DEF   = 32;
    localparam int CIC_W          = 33;
    localparam int SAMPLE_W       = 55;
    localparam int COEF_W         = 16;
    localparam int DECIM_W        = 9;
    localparam logic [DECIM_W-1:0] DECIM_RESET = 9'd64;

    typedef enum logic {FUNC_DATA = 1'b0, FUNC_COEF = 1'b1} func_t;

    typedef enum logic [1:0] {BK_IDLE, BK_BITS, BK_FIR, BK_OUT} bk_state_t;

    // One queued item between front and back.
    typedef struct packed {
        func_t       func;
        logic [31:0] pdm_word;
        logic [7:0]  coef_index;
        logic [15:0] coef_value;
    } item_t;
endpackage

// ===== design/pdm_cic_fir_decimator.sv =====
// Top level of the PDM CIC/FIR decimator.
// Depends on pcfd_pkg, pcfd_front and pcfd_back.
// A data item (tuser = 0) holds 32 PDM bits, processed MSB first one bit per
// cycle through the integrators, pausing while each decimated sample runs
// through the tap-serial FIR multiply-accumulate and is handed to the output
// register; that hand-off waits while the output register still holds an
// unaccepted sample. A coefficient item (tuser = 1) yields nothing; an index
// at or beyond FIR_TAPS is dropped. Each result carries tlast on the final
// sample a word causes. A two-item queue sits in front, so the next items are
// accepted while the back end works. Decimation 0 acts as 1, and any value
// above 256 acts as 256.
module pdm_cic_fir_decimator
    import pcfd_pkg::*;
#(
    parameter int NUM_STAGES = NUM_STAGES_DEF,
    parameter int COMB_DELAY = COMB_DELAY_DEF,
    parameter int FIR_TAPS   = FIR_TAPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DECIM_W-1:0] cfg_wdata,     // decimation
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [55:0]        s_axis_tdata,  // pdm_word[31:0], coef_index[39:32], coef_value[55:40]
    input  logic               s_axis_tuser,  // func
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [55:0]        m_axis_tdata,  // sample[54:0], zero pad
    output logic               m_axis_tlast   // last
);
    logic [DECIM_W-1:0] decim_reg;
    item_t in_item, q_item;
    logic  q_valid, q_ready;
    logic [SAMPLE_W-1:0] sample;

    // Hold the decimation register; write on enable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decim_reg <= DECIM_RESET;
        else if (cfg_we)
            decim_reg <= cfg_wdata;
    end

    assign in_item.func       = func_t'(s_axis_tuser);
    assign in_item.pdm_word   = s_axis_tdata[31:0];
    assign in_item.coef_index = s_axis_tdata[39:32];
    assign in_item.coef_value = s_axis_tdata[55:40];

    pcfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pcfd_back #(
        .NUM_STAGES (NUM_STAGES),
        .COMB_DELAY (COMB_DELAY),
        .FIR_TAPS   (FIR_TAPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .decimation (decim_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (sample),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, sample};
endmodule

// ===== design/pcfd_front.sv =====
// Front end: accepts items and holds them in a two-entry queue.
// Depends on pcfd_pkg.
module pcfd_front
    import pcfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);
    item_t    mem_reg [2];
    logic     wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic     push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count invalid");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
`endif
endmodule

// ===== design/pcfd_back.sv =====
// Back end: bit-serial CIC, tap-serial FIR MAC and output register.
// Depends on pcfd_pkg.
module pcfd_back
    import pcfd_pkg::*;
#(
    parameter int NUM_STAGES = NUM_STAGES_DEF,
    parameter int COMB_DELAY = COMB_DELAY_DEF,
    parameter int FIR_TAPS   = FIR_TAPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DECIM_W-1:0]  decimation,
    input  logic                q_valid,
    output logic                q_ready,
    input  item_t               q_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SAMPLE_W-1:0] out_sample,
    output logic                out_last
);
    localparam int RING_LEN = (FIR_TAPS > 1) ? FIR_TAPS - 1 : 1;
    localparam int HP_W     = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;
    localparam int TAP_W    = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
    localparam int CD_W     = (COMB_DELAY > 1) ? $clog2(COMB_DELAY) : 1;
    localparam int PROD_W   = CIC_W + COEF_W;

    bk_state_t state_reg, state_next;

    logic [CIC_W-1:0]  integ_reg [NUM_STAGES];
    logic [CIC_W-1:0]  comb_reg  [NUM_STAGES][COMB_DELAY];
    logic [CD_W-1:0]   cptr_reg;
    logic [7:0]        phase_reg;
    logic [4:0]        bit_reg;
    logic [31:0]       word_reg;
    logic [CIC_W-1:0]  x_reg;
    logic              more_reg;
    logic              last_reg;

    logic [COEF_W-1:0] coef_mem [FIR_TAPS];
    logic [FIR_TAPS-1:0] coef_vld_reg;
    logic [CIC_W-1:0]  hist_mem [RING_LEN];
    logic [RING_LEN-1:0] hist_vld_reg;
    logic [HP_W-1:0]   hptr_reg;

    logic [TAP_W:0]    tap_reg;
    logic [HP_W-1:0]   rd_idx_reg;
    logic [SAMPLE_W-1:0] acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_vld_reg;
    logic [COEF_W-1:0] c_rd_reg;
    logic [CIC_W-1:0]  h_rd_reg;
    logic              rd_vld_reg;

    logic [8:0]        ratio;
    logic [CIC_W-1:0]  integ_next [NUM_STAGES];
    logic [CIC_W-1:0]  y_comb;
    logic [7:0]        phase_inc;
    logic              fire;
    logic              bits_done;

    assign ratio = (decimation == '0) ? 9'd1 : decimation;

    always_comb
    begin
        logic [CIC_W-1:0] x;
        x = word_reg[31] ? CIC_W'(1) : '1;
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            integ_next[s] = integ_reg[s] + x;
            x = integ_next[s];
        end
        y_comb = x;
        for (int s = 0; s < NUM_STAGES; s++)
            y_comb = y_comb - comb_reg[s][cptr_reg];
    end

    // The comb subtraction above chains NUM_STAGES differences on the
    // pre-delay values; each stage input is the previous stage output.
    logic [CIC_W-1:0] comb_in [NUM_STAGES];
    always_comb
    begin
        logic [CIC_W-1:0] y;
        y = integ_next[NUM_STAGES-1];
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            comb_in[s] = y;
            y = y - comb_reg[s][cptr_reg];
        end
    end

    assign phase_inc = phase_reg + 8'd1;
    assign fire      = (phase_inc == 8'd0) || ({1'b0, phase_inc} >= ratio);
    assign bits_done = (bit_reg == 5'd31);

    assign q_ready = (state_reg == BK_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid && q_item.func == FUNC_DATA) state_next = BK_BITS;
            BK_BITS:
                if (fire) state_next = BK_FIR;
                else if (bits_done) state_next = BK_IDLE;
            BK_FIR:
                if (!rd_vld_reg && !prod_vld_reg && tap_reg == (TAP_W+1)'(FIR_TAPS))
                    state_next = BK_OUT;
            BK_OUT:
                if (!out_valid || out_ready)
                    state_next = more_reg ? BK_BITS : BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    logic start_fir;
    assign start_fir = (state_reg == BK_BITS) && fire;

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && q_valid && q_item.func == FUNC_DATA)
            word_reg <= q_item.pdm_word;
        else if (state_reg == BK_BITS)
            word_reg <= {word_reg[30:0], 1'b0};
        if (start_fir)
        begin
            x_reg    <= y_comb;
            more_reg <= !bits_done;
            // Final sample of the word when the remaining bits cannot reach
            // the ratio again
            last_reg <= ({4'b0, 5'd31 - bit_reg} < ratio);
        end
        if (state_reg == BK_IDLE && q_valid && q_item.func == FUNC_COEF
            && {1'b0, q_item.coef_index} < 9'(FIR_TAPS))
            coef_mem[q_item.coef_index[TAP_W-1:0]] <= q_item.coef_value;
        // Tap-serial read of coefficient and history.
        c_rd_reg <= coef_vld_reg[tap_reg[TAP_W-1:0]] ? coef_mem[tap_reg[TAP_W-1:0]] : '0;
        h_rd_reg <= (tap_reg == '0) ? x_reg :
                    (hist_vld_reg[rd_idx_reg] ? hist_mem[rd_idx_reg] : '0);
        prod_reg <= PROD_W'($signed(c_rd_reg) * $signed(h_rd_reg));
        if (state_next == BK_OUT && state_reg == BK_FIR && FIR_TAPS > 1)
            hist_mem[hptr_reg] <= x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                integ_reg[s] <= '0;
                for (int d = 0; d < COMB_DELAY; d++) comb_reg[s][d] <= '0;
            end
            cptr_reg     <= '0;
            phase_reg    <= 8'd63;
            bit_reg      <= '0;
            coef_vld_reg <= '0;
            hist_vld_reg <= '0;
            hptr_reg     <= '0;
            tap_reg      <= '0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
            out_valid    <= 1'b0;
            out_sample   <= '0;
            out_last     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_IDLE && q_valid && q_item.func == FUNC_COEF
                && {1'b0, q_item.coef_index} < 9'(FIR_TAPS))
                coef_vld_reg[q_item.coef_index[TAP_W-1:0]] <= 1'b1;
            if (state_reg == BK_BITS)
            begin
                for (int s = 0; s < NUM_STAGES; s++) integ_reg[s] <= integ_next[s];
                bit_reg   <= bit_reg + 5'd1;
                phase_reg <= fire ? 8'd0 : phase_inc;
                if (fire)
                begin
                    for (int s = 0; s < NUM_STAGES; s++) comb_reg[s][cptr_reg] <= comb_in[s];
                    cptr_reg   <= (cptr_reg == CD_W'(COMB_DELAY-1)) ? '0 : cptr_reg + 1'b1;
                    tap_reg    <= '0;
                    rd_idx_reg <= (hptr_reg == '0) ? HP_W'(RING_LEN-1) : hptr_reg - 1'b1;
                    acc_reg    <= '0;
                    rd_vld_reg <= 1'b0;
                    prod_vld_reg <= 1'b0;
                end
            end
            if (state_reg == BK_FIR)
            begin
                rd_vld_reg   <= (tap_reg != (TAP_W+1)'(FIR_TAPS));
                prod_vld_reg <= rd_vld_reg;
                if (prod_vld_reg) acc_reg <= acc_reg + SAMPLE_W'($signed(prod_reg));
                if (tap_reg != (TAP_W+1)'(FIR_TAPS))
                begin
                    tap_reg <= tap_reg + 1'b1;
                    if (tap_reg != '0)
                        rd_idx_reg <= (rd_idx_reg == '0) ? HP_W'(RING_LEN-1)
                                                         : rd_idx_reg - 1'b1;
                end
                if (state_next == BK_OUT && FIR_TAPS > 1)
                begin
                    hist_vld_reg[hptr_reg] <= 1'b1;
                    hptr_reg <= (hptr_reg == HP_W'(RING_LEN-1)) ? '0 : hptr_reg + 1'b1;
                end
            end
            if (state_reg == BK_OUT && (!out_valid || out_ready))
            begin
                out_valid  <= 1'b1;
                out_sample <= acc_reg;
                out_last   <= last_reg;
                if (!more_reg) bit_reg <= '0;
            end
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == BK_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
        else $error("result dropped");
    a_bit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_IDLE |-> bit_reg == '0) else $error("bit counter stale");
`endif
endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for pdm_cic_fir_decimator: table-driven directed items,
// then phases of random items under several decimation ratios.
// Depends on pcfd_pkg and the design top level.
module tb_top;
    import pcfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 200;   // cycles to let the back end drain
    localparam int RING_LEN    = FIR_TAPS_DEF - 1;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } pcm_t;

    // Directed row: one item, optionally with the sample value typed in.
    typedef struct {
        func_t       func;
        logic [31:0] word;
        logic [7:0]  idx;
        logic [15:0] val;
        bit          typed;
        logic [SAMPLE_W-1:0] smp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [DECIM_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic m_axis_tlast;

    // Prediction state of the decimator
    logic [DECIM_W-1:0]  mdl_decim;
    logic [CIC_W-1:0]    mdl_integ [NUM_STAGES_DEF];
    logic [CIC_W-1:0]    mdl_comb  [NUM_STAGES_DEF];
    logic [7:0]          mdl_phase;
    logic [CIC_W-1:0]    mdl_hist  [RING_LEN];
    int                  mdl_hptr;
    logic signed [15:0]  mdl_coef  [FIR_TAPS_DEF];

    pcm_t pending_pcm[$];
    int   errors = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;
    bit   long_hold_req = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;

    pdm_cic_fir_decimator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pdm_word, coef_index, coef_value
        .s_axis_tuser  (s_axis_tuser),   // func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // sample, zero pad
        .m_axis_tlast  (m_axis_tlast)    // last
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic void pcm_reset();
        mdl_decim = DECIM_RESET;
        mdl_phase = 8'd63;
        mdl_hptr  = 0;
        for (int s = 0; s < NUM_STAGES_DEF; s++)
        begin
            mdl_integ[s] = '0;
            mdl_comb[s]  = '0;
        end
        for (int k = 0; k < RING_LEN; k++)
            mdl_hist[k] = '0;
        for (int k = 0; k < FIR_TAPS_DEF; k++)
            mdl_coef[k] = '0;
    endfunction

    // Compensation FIR over the CIC sample and the history ring
    function automatic logic [SAMPLE_W-1:0] fir_sum(input logic [CIC_W-1:0] x);
        longint acc;
        int back;
        acc = longint'(mdl_coef[0]) * longint'($signed(x));
        for (int k = 1; k < FIR_TAPS_DEF; k++)
        begin
            back = (mdl_hptr + RING_LEN - k) % RING_LEN;
            acc += longint'(mdl_coef[k]) * longint'($signed(mdl_hist[back]));
        end
        mdl_hist[mdl_hptr] = x;
        mdl_hptr = (mdl_hptr + 1) % RING_LEN;
        return acc[SAMPLE_W-1:0];
    endfunction

    // Advance the model by one accepted item and queue the samples it yields
    function automatic void pcm_predict(input func_t f, input logic [31:0] word,
                                        input logic [7:0] idx, input logic [15:0] val);
        int ratio;
        int first;
        logic [CIC_W-1:0] x;
        logic [CIC_W-1:0] y;
        logic [CIC_W-1:0] old;
        pcm_t p;
        if (f == FUNC_COEF)
        begin
            if (idx < FIR_TAPS_DEF)
                mdl_coef[idx] = $signed(val);
            return;
        end
        ratio = (mdl_decim == 0) ? 1 : (mdl_decim > 256) ? 256 : int'(mdl_decim);
        first = pending_pcm.size();
        for (int b = 31; b >= 0; b--)
        begin
            x = word[b] ? 33'd1 : {CIC_W{1'b1}};
            for (int s = 0; s < NUM_STAGES_DEF; s++)
            begin
                mdl_integ[s] = mdl_integ[s] + x;
                x = mdl_integ[s];
            end
            mdl_phase = mdl_phase + 8'd1;
            if (mdl_phase == 0 || int'(mdl_phase) >= ratio)
            begin
                mdl_phase = '0;
                y = x;
                for (int s = 0; s < NUM_STAGES_DEF; s++)
                begin
                    old = mdl_comb[s];
                    mdl_comb[s] = y;
                    y = y - old;
                end
                p.sample = fir_sum(y);
                p.last = 1'b0;
                pending_pcm.push_back(p);
            end
        end
        if (pending_pcm.size() > first)
            pending_pcm[pending_pcm.size()-1].last = 1'b1;
    endfunction

    // Offer one item, with an optional gap first, and hold until accepted
    task automatic send_item(input func_t f, input logic [31:0] word,
                             input logic [7:0] idx, input logic [15:0] val);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, idx, word};
        s_axis_tuser  <= f;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pcm_predict(f, word, idx, val);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pcm.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_decim(input logic [DECIM_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_decim = v;
    endtask

    // Random item: mostly PDM words, some coefficient loads
    task automatic send_random();
        logic [31:0] w;
        logic [7:0] ix;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            // Mostly real taps, now and then an out-of-range index
            ix = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
            send_item(FUNC_COEF, $urandom, ix, 16'($urandom));
        end
        else
        begin
            w = (pick == 3) ? 32'hFFFF_FFFF : (pick == 4) ? 32'h0 : $urandom;
            send_item(FUNC_DATA, w, 8'($urandom), 16'($urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off on request, none when quiet
    always @(posedge clk)
    begin
        if (long_hold_req && !hold_taken)
        begin
            hold_taken    <= 1'b1;
            hold_left     <= 3000;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare every accepted sample with the oldest expectation
    always @(posedge clk)
    begin
        pcm_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pcm.size() == 0)
                report("unexpected sample", 64'(m_axis_tdata), 64'd0);
            else
            begin
                want = pending_pcm.pop_front();
                if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample)
                    report("sample", 64'(m_axis_tdata[SAMPLE_W-1:0]), 64'(want.sample));
                if (m_axis_tlast !== want.last)
                    report("last", 64'(m_axis_tlast), 64'(want.last));
            end
        end
    end

    row_t directed [] = '{
        // All taps zero after reset: every sample reads zero
        '{FUNC_DATA, 32'hFFFF_FFFF, 8'd0,   16'h0000, 1'b1, 55'd0},
        '{FUNC_DATA, 32'h0000_0000, 8'd0,   16'h0000, 1'b1, 55'd0},
        '{FUNC_DATA, 32'hAAAA_AAAA, 8'hFF,  16'hFFFF, 1'b1, 55'd0},
        // Coefficient extremes, plus indices past the last tap (dropped)
        '{FUNC_COEF, 32'hFFFF_FFFF, 8'd0,   16'h7FFF, 1'b0, 55'd0},
        '{FUNC_COEF, 32'h0,         8'd31,  16'h8000, 1'b0, 55'd0},
        '{FUNC_COEF, 32'h0,         8'd1,   16'hFFFF, 1'b0, 55'd0},
        '{FUNC_COEF, 32'h0,         8'd32,  16'h1234, 1'b0, 55'd0},
        '{FUNC_COEF, 32'h0,         8'd255, 16'h5A5A, 1'b0, 55'd0},
        '{FUNC_COEF, 32'h0,         8'd15,  16'h0001, 1'b0, 55'd0},
        '{FUNC_DATA, 32'hFFFF_FFFF, 8'd0,   16'h0000, 1'b0, 55'd0},
        '{FUNC_DATA, 32'h0000_0000, 8'd0,   16'h0000, 1'b0, 55'd0},
        '{FUNC_DATA, 32'h5555_5555, 8'd0,   16'h0000, 1'b0, 55'd0},
        '{FUNC_DATA, 32'h8000_0001, 8'd0,   16'h0000, 1'b0, 55'd0},
        '{FUNC_DATA, 32'h7FFF_FFFE, 8'd0,   16'h0000, 1'b0, 55'd0},
        '{FUNC_DATA, 32'hFFFF_0000, 8'd0,   16'h0000, 1'b0, 55'd0},
        '{FUNC_COEF, 32'h0,         8'd0,   16'h8000, 1'b0, 55'd0},
        '{FUNC_DATA, 32'hFFFF_FFFF, 8'd0,   16'h0000, 1'b0, 55'd0}
    };

    // Ratio per phase: 1, 0 (acts as 1), 256, above 256, then 2, 3, 7 and 100
    logic [DECIM_W-1:0] ratios [] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'd3, 9'd7, 9'd100};

    initial
    begin
        int first;
        pcm_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; overwrite predicted samples where a value is typed in
        foreach (directed[i])
        begin
            first = pending_pcm.size();
            send_item(directed[i].func, directed[i].word, directed[i].idx, directed[i].val);
            if (directed[i].typed)
                for (int k = first; k < pending_pcm.size(); k++)
                    pending_pcm[k].sample = directed[i].smp;
        end

        foreach (ratios[p])
        begin
            write_decim(ratios[p]);
            // Fill the block while the receiver holds off at the densest ratio
            if (ratios[p] == 9'd1)
                long_hold_req = 1'b1;
            // Steady all-ones input at 256 drives the CIC to its +2^32 wrap
            if (ratios[p] == 9'd256)
            begin
                send_item(FUNC_COEF, 32'h0, 8'd0, 16'h0001);
                repeat (48) send_item(FUNC_DATA, 32'hFFFF_FFFF, 8'd0, 16'h0);
            end
            repeat (5) send_random();
        end

        // Final phase at a random ratio with no idling on either side
        write_decim(9'($urandom_range(1, 256)));
        quiet = 1'b1;
        repeat (12) send_random();

        wait_drained();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
design/pcfd_pkg.sv
design/pcfd_front.sv
design/pcfd_back.sv
design/pdm_cic_fir_decimator.sv
dv/tb_top.sv
